/* rtl/sgm_pkg.sv */
package sgm_pkg;

    localparam int MaxWidth   = 1024;
    localparam int PixelBits  = 8;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int RowBits    = 12;
    localparam int MaxHeight  = 4095;
    localparam int EnergyBits = 21;
    localparam int RootBits   = 11;

    localparam logic [0:0] OP_PIXEL = 1'b0;
    localparam logic [0:0] OP_DRAIN = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [PixelBits-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          edge_value;
        logic [RootBits-1:0] magnitude;
        logic                is_border;
        logic                last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic                 border;
        logic                 last;
        logic [PixelBits-1:0] center;
    } t_side;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ROOT,
        ST_OUT
    } t_state;

endpackage

/* rtl/sobel_gradient_magnitude.sv */
// sobel 3x3 gradient magnitude over 8-bit grayscale frames
// input channel: one request per pixel in raster order (operation pixel),
// then drain requests (operation drain) after the frame's last pixel push
// out the final image_width + 1 results
// output channel: one result per request once a line plus one pixel of
// the frame is in; edge_value, magnitude, is_border, last_of_frame
// configuration channel: index 0 image_width, index 1 image_height;
// a write restarts the frame counters and goes ahead of a waiting request
// an interior pixel's request reads both line stores in the read state, then
// its result is worked out by the one-bit-per-cycle square root; a border
// pixel's result goes from the read state through the output state
// the block takes no new request until the previous one has finished, so
// requests wait on the square root for interior pixels
// the output register holds a result while the receiver stalls; a new
// request is taken the cycle after the previous result has been handed over
// reset restores 640 x 480 and clears counters and window; line stores
// need no clearing since stale entries never reach a result
module sobel_gradient_magnitude
    import sgm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [10:0]          r_width;
    logic [RowBits-1:0]   r_height;
    logic [ColBits-1:0]   r_col;
    logic [RowBits:0]     r_row;
    logic [21:0]          r_emitted;
    logic [PixelBits-1:0] r_win [9];
    logic [PixelBits-1:0] r_pix;
    logic [ColBits-1:0]   r_acol;
    logic                 r_emit;
    t_side                r_side;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [10:0]          eff_w;
    logic [RowBits-1:0]   eff_h;
    logic [21:0]          total;
    logic                 draining;
    logic                 in_fire, out_fire, cfg_fire;
    logic                 take;
    logic [PixelBits-1:0] up_rd, mid_rd;
    logic                 root_start, root_done;
    logic [RootBits-1:0]  root;
    logic [EnergyBits-1:0] energy;
    logic [RowBits:0]     rr;
    logic [10:0]          cc;
    logic                 border;
    logic signed [11:0]   gx, gy;

    // effective geometry
    always_comb begin
        eff_w = r_width;
        if (r_width < 11'd3) eff_w = 11'd3;
        if (r_width > 11'(MaxWidth)) eff_w = 11'(MaxWidth);
        eff_h = r_height;
        if (r_height < 12'd3) eff_h = 12'd3;
    end

    assign total    = 22'(eff_w) * 22'(eff_h);
    assign draining = r_row >= {1'b0, eff_h};

    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign take     = in_fire && (draining || i_in_data.operation == OP_PIXEL);

    // line stores
    sgm_ram #(.Width(PixelBits), .Depth(MaxWidth)) u_upper (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_READ),
        .i_waddr(r_acol),
        .i_wdata(mid_rd),
        .i_raddr(r_col),
        .o_rdata(up_rd)
    );

    sgm_ram #(.Width(PixelBits), .Depth(MaxWidth)) u_middle (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_READ),
        .i_waddr(r_acol),
        .i_wdata(r_pix),
        .i_raddr(r_col),
        .o_rdata(mid_rd)
    );

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (take) n_state = ST_READ;
            ST_READ: n_state = !r_emit ? ST_IDLE : (r_side.border ? ST_OUT : ST_ROOT);
            ST_ROOT: if (root_done) n_state = ST_IDLE;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign root_start = (r_state == ST_READ) && r_emit && !r_side.border;

    // gradient from the window after the shift of this request
    always_comb begin
        gx = (12'(r_win[1]) + 12'({r_win[4], 1'b0}) + 12'(r_win[7]))
           - (12'(up_rd) + 12'({mid_rd, 1'b0}) + 12'(r_pix));
        gy = (12'(r_win[1]) + 12'({r_win[2], 1'b0}) + 12'(up_rd))
           - (12'(r_win[7]) + 12'({r_win[8], 1'b0}) + 12'(r_pix));
    end

    logic [21:0] gx2, gy2;
    assign gx2 = 22'(gx * gx);
    assign gy2 = 22'(gy * gy);
    assign energy = EnergyBits'(gx2 + gy2);

    sgm_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(root_start),
        .i_value(energy),
        .o_done (root_done),
        .o_root (root)
    );

    // position of the pixel whose result this request produces
    always_comb begin
        if (r_col != '0) begin
            rr = r_row - 1'b1;
            cc = {1'b0, r_col} - 1'b1;
        end else begin
            rr = r_row - 2'd2;
            cc = eff_w - 1'b1;
        end
        border = (rr == '0) || (rr >= {1'b0, eff_h - 1'b1}) || (cc == '0)
              || (cc >= eff_w - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        r_state <= !i_rst_n ? ST_IDLE : n_state;
    end

    // counters, configuration and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 11'd640;
            r_height    <= 12'd480;
            r_col       <= '0;
            r_row       <= '0;
            r_emitted   <= '0;
            r_out_valid <= 1'b0;
            r_emit      <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (out_fire) r_out_valid <= 1'b0;
            if (cfg_fire) begin
                if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data[10:0];
                else r_height <= i_cfg_data;
                r_col     <= '0;
                r_row     <= '0;
                r_emitted <= '0;
            end else if (take) begin
                r_pix  <= draining ? '0 : i_in_data.pixel_in;
                r_acol <= r_col;
                r_emit <= !((r_row == '0) || (r_row == 13'd1 && r_col == '0));
                r_side.border <= border;
                r_side.last   <= (r_emitted + 1'b1) >= total;
                r_side.center <= r_win[5];
                if ({1'b0, r_col} + 1'b1 >= eff_w) begin
                    r_col <= '0;
                    if (r_row < 13'(MaxHeight + 1)) r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                if (!((r_row == '0) || (r_row == 13'd1 && r_col == '0))) begin
                    if ((r_emitted + 1'b1) >= total) begin
                        r_emitted <= '0;
                        r_col     <= '0;
                        r_row     <= '0;
                    end else begin
                        r_emitted <= r_emitted + 1'b1;
                    end
                end
            end
            if (r_state == ST_READ) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= up_rd;
                r_win[5] <= mid_rd;
                r_win[8] <= r_pix;
                if (r_emit && r_side.border) begin
                    r_out.edge_value    <= r_side.center;
                    r_out.magnitude     <= '0;
                    r_out.is_border     <= 1'b1;
                    r_out.last_of_frame <= r_side.last;
                end
            end
            if (r_state == ST_OUT) r_out_valid <= 1'b1;
            if (r_state == ST_ROOT && root_done) begin
                r_out.edge_value    <= (root > 11'd255) ? 8'hFF : root[7:0];
                r_out.magnitude     <= root;
                r_out.is_border     <= 1'b0;
                r_out.last_of_frame <= r_side.last;
                r_out_valid         <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready) else $error("request taken while result pending");
    a_root_only_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> r_state == ST_ROOT) else $error("root finished outside root state");
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_ROOT || $past(r_state) == ST_OUT)
        else $error("result without work");
`endif

endmodule

/* rtl/sgm_ram.sv */
module sgm_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sgm_isqrt.sv */
module sgm_isqrt
    import sgm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [EnergyBits-1:0] i_value,
    output logic                  o_done,
    output logic [RootBits-1:0]   o_root
);

    localparam int Steps   = RootBits;
    localparam int StepBits = $clog2(Steps + 1);

    logic [EnergyBits+1:0] r_rem, n_rem;
    logic [RootBits-1:0]   r_root, n_root;
    logic [EnergyBits+1:0] r_src, n_src;
    logic [StepBits-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic [EnergyBits+1:0] trial;
    logic [EnergyBits+1:0] rem_sh;

    // one result bit per cycle, restoring method
    always_comb begin
        rem_sh = {r_rem[EnergyBits-1:0], r_src[EnergyBits+1:EnergyBits]};
        trial  = {{(EnergyBits-RootBits){1'b0}}, r_root, 2'b01};
        n_rem  = r_rem;
        n_root = r_root;
        n_src  = r_src;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_root = '0;
            n_src  = {1'b0, i_value, 1'b0};
            n_cnt  = StepBits'(Steps);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_src = {r_src[EnergyBits-1:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[RootBits-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[RootBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == StepBits'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_src  <= n_src;
    end

    assign o_done = r_busy && (r_cnt == StepBits'(1));
    assign o_root = {r_root[RootBits-2:0], (rem_sh >= trial)};

endmodule

/* verif/sobel_gradient_magnitude_tb.sv */
`timescale 1ns / 100ps

module sobel_gradient_magnitude_tb;
    import sgm_pkg::*;

    localparam int HoldOff   = 24;
    localparam int CycleCap  = 1000000;
    localparam int CalmItems = 120;

    typedef struct {
        bit          is_cfg;
        t_in_item    pix_req;
        logic        reg_idx;
        logic [11:0] reg_val;
    } t_request;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_index = 1'b0;
    logic [11:0] i_cfg_data = '0;

    sobel_gradient_magnitude uut (.*);

    always #5 i_clk = ~i_clk;

    // sobel state mirror
    int unsigned width_reg, height_reg;
    logic [7:0]  upper_line[MaxWidth];
    logic [7:0]  middle_line[MaxWidth];
    logic [7:0]  win[9];
    int unsigned in_col, in_row, emitted;

    t_request  pending_reqs[$];
    t_out_item expected_pixels[$];
    int        mismatches = 0;
    int        cycles = 0;

    function automatic int unsigned frame_width();
        return width_reg < 3 ? 3 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    endfunction

    function automatic int unsigned frame_height();
        return height_reg < 3 ? 3 : (height_reg > MaxHeight ? MaxHeight : height_reg);
    endfunction

    function automatic int unsigned floor_root(int unsigned e);
        int unsigned m;
        m = 0;
        while ((m + 1) * (m + 1) <= e) m++;
        return m;
    endfunction

    function automatic void apply_register(logic idx, logic [11:0] val);
        if (idx == REG_WIDTH) width_reg = val[10:0];
        else width_reg = width_reg;
        if (idx == REG_HEIGHT) height_reg = val;
        in_col = 0;
        in_row = 0;
        emitted = 0;
    endfunction

    // advance the window by one request and queue the pixel it completes
    function automatic void sobel_advance(t_in_item req);
        int unsigned w, h, pix, c, r, col, row, mag, e;
        int          gx, gy;
        bit          draining, border;
        t_out_item   res;
        w = frame_width();
        h = frame_height();
        draining = in_row >= h;
        if (!draining && req.operation == OP_DRAIN) return;
        pix = draining ? 0 : req.pixel_in;
        col = in_col;
        row = in_row;
        if (col >= MaxWidth) col = 0;
        for (int i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_line[col];
        win[5] = middle_line[col];
        win[8] = pix[7:0];
        upper_line[col] = middle_line[col];
        middle_line[col] = pix[7:0];
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < MaxHeight + 1) in_row++;
        end else begin
            in_col++;
        end
        if (row == 0 || (row == 1 && col == 0)) return;
        if (col >= 1) begin
            r = row - 1;
            c = col - 1;
        end else begin
            r = row - 2;
            c = w - 1;
        end
        border = (r == 0 || r >= h - 1 || c == 0 || c >= w - 1);
        mag = 0;
        if (border) begin
            res.edge_value = win[4];
        end else begin
            gx = (int'(win[0]) + 2*int'(win[3]) + int'(win[6]))
               - (int'(win[2]) + 2*int'(win[5]) + int'(win[8]));
            gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
               - (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
            e = gx*gx + gy*gy;
            mag = floor_root(e);
            res.edge_value = mag > 255 ? 8'd255 : mag[7:0];
        end
        emitted++;
        res.magnitude = mag[RootBits-1:0];
        res.is_border = border;
        res.last_of_frame = emitted >= w * h;
        if (emitted >= w * h) begin
            in_col = 0;
            in_row = 0;
            emitted = 0;
        end
        expected_pixels.push_back(res);
    endfunction

    // stimulus builders
    function automatic void queue_register(logic idx, logic [11:0] val);
        t_request q;
        q.is_cfg = 1'b1;
        q.pix_req = '0;
        q.reg_idx = idx;
        q.reg_val = val;
        pending_reqs.push_back(q);
    endfunction

    function automatic void queue_pixel(logic op, logic [7:0] pix);
        t_request q;
        q.is_cfg = 1'b0;
        q.pix_req.operation = op;
        q.pix_req.pixel_in = pix;
        q.reg_idx = REG_WIDTH;
        q.reg_val = '0;
        pending_reqs.push_back(q);
    endfunction

    // style 0 random, 1 extremes only, 2 checker; cut < w*h aborts the frame
    function automatic void queue_frame(int w, int h, int style, int cut, bit noisy);
        int n;
        logic [7:0] p;
        n = (cut < w * h) ? cut : w * h;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: p = $urandom_range(0, 255);
                1: p = $urandom_range(0, 1) ? 8'hff : 8'h00;
                default: p = (((i % w) + (i / w)) % 2) ? 8'hff : 8'h00;
            endcase
            // early drain ticks are ignored by the block
            if (noisy && $urandom_range(0, 15) == 0)
                queue_pixel(OP_DRAIN, $urandom_range(0, 255));
            queue_pixel(OP_PIXEL, p);
        end
        if (n < w * h) return;
        // drain, some as pushes that the block treats as drain ticks
        for (int i = 0; i <= w; i++)
            queue_pixel((noisy && $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN,
                        $urandom_range(0, 255));
    endfunction

    // driver
    int   in_gap = 0;
    int   quiet = 0;
    logic nxt_valid, nxt_cfg_valid;
    always @(posedge i_clk) begin
        t_request q;
        bit calm;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet = 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_cfg_valid = i_cfg_valid;
            calm = pending_reqs.size() < CalmItems;
            if (i_in_valid && o_in_ready) begin
                sobel_advance(i_in_data);
                nxt_valid = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
                nxt_cfg_valid = 1'b0;
            end
            if (expected_pixels.size() == 0 && !i_in_valid && !i_cfg_valid) quiet++;
            else quiet = 0;
            if (!nxt_valid && !nxt_cfg_valid && pending_reqs.size() > 0) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_reqs[0].is_cfg) begin
                    if (quiet >= HoldOff) begin
                        q = pending_reqs.pop_front();
                        nxt_cfg_valid = 1'b1;
                        i_cfg_index <= q.reg_idx;
                        i_cfg_data  <= q.reg_val;
                    end
                end else begin
                    q = pending_reqs.pop_front();
                    nxt_valid = 1'b1;
                    i_in_data <= q.pix_req;
                    if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
                end
            end
            i_in_valid  <= nxt_valid;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // monitor with random receiver stalls
    int out_stall = 0;
    always @(posedge i_clk) begin
        t_out_item exp_px;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_out_data);
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (o_out_data.edge_value !== exp_px.edge_value
                        || o_out_data.magnitude !== exp_px.magnitude
                        || o_out_data.is_border !== exp_px.is_border
                        || o_out_data.last_of_frame !== exp_px.last_of_frame) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p actual %p",
                                     exp_px, o_out_data);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else if (pending_reqs.size() >= CalmItems && $urandom_range(0, 5) == 0) begin
                out_stall = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleCap) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int w, h, budget;
        width_reg = 640;
        height_reg = 480;
        in_col = 0;
        in_row = 0;
        emitted = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        for (int i = 0; i < MaxWidth; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end

        // directed: smallest frames with extreme and checker content
        queue_register(REG_WIDTH, 12'd3);
        queue_register(REG_HEIGHT, 12'd3);
        queue_pixel(OP_DRAIN, 8'h5a);
        queue_frame(3, 3, 2, 9, 1'b0);
        queue_frame(3, 3, 1, 9, 1'b1);
        // out-of-range values clamp to 3 x 3
        queue_register(REG_WIDTH, 12'h800);
        queue_register(REG_HEIGHT, 12'd0);
        queue_frame(3, 3, 1, 9, 1'b0);

        // width above range clamps; tallest frame aborted after a few pixels
        queue_register(REG_WIDTH, 12'h7ff);
        queue_register(REG_HEIGHT, 12'd4095);
        queue_frame(1024, 4095, 1, 40, 1'b1);
        queue_register(REG_HEIGHT, 12'hfff);
        queue_register(REG_WIDTH, 12'd5);
        queue_frame(5, 4095, 0, 40, 1'b0);

        // random frames, small sizes, occasional aborts
        budget = 480;
        while (budget > 0) begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 6);
            queue_register(REG_WIDTH, {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'(w)});
            queue_register(REG_HEIGHT, 12'(h));
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                queue_frame(w, h, $urandom_range(0, 5) == 0 ? 1 : 0,
                            $urandom_range(0, 7) == 0 ? $urandom_range(1, w * h) : w * h,
                            1'b1);
                budget -= w * h + w + 1;
            end
        end

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !i_in_valid && !i_cfg_valid);
        wait (expected_pixels.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
